/* hdl/chsr_pkg.sv */
// Shared constants, codes and controller/datapath interface types for the heat-map strip renderer.
`default_nettype none
package chsr_pkg;

    localparam int WIDTH_MAX    = 256;
    localparam int CORES_MAX    = 8;
    localparam int PALETTE_SIZE = 1000;

    localparam int COL_W       = 8;
    localparam int ROW_W       = 4;
    localparam int CORE_W      = 3;
    localparam int FRAME_AW    = ROW_W + COL_W;
    localparam int FRAME_DEPTH = 1 << FRAME_AW;
    localparam int PAL_AW      = 10;
    localparam int PIX_W       = 32;
    localparam int FREQ_W      = 16;
    localparam int USAGE_W     = 10;
    localparam int NUM_W       = 26;
    localparam int QUO_W       = 10;
    localparam int MODE_W      = 3;
    localparam int CNT_W       = 4;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;
    localparam int CFG_COLS_W = 9;
    localparam int CFG_CORE_W = 4;

    localparam logic [PAL_AW-1:0]     CLAMP_MAX   = PAL_AW'(999);
    localparam logic [PAL_AW-1:0]     FREQ_SCALE  = PAL_AW'(1000);
    localparam logic [CFG_COLS_W-1:0] COLS_MAX    = CFG_COLS_W'(WIDTH_MAX);
    localparam logic [CFG_COLS_W-1:0] COLS_RESET  = CFG_COLS_W'(256);
    localparam logic [CFG_CORE_W-1:0] CORES_LIMIT = CFG_CORE_W'(CORES_MAX);
    localparam logic [CFG_CORE_W-1:0] CORES_RESET = CFG_CORE_W'(1);
    localparam logic                  LAYOUT_RESET = 1'b1;

    localparam logic [CNT_W-1:0] DIV_STEPS = CNT_W'(QUO_W);
    localparam logic [CNT_W-1:0] MOD_STEPS = CNT_W'(CFG_COLS_W);

    localparam logic [CFG_IDX_W-1:0] CFG_COLUMNS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CORES   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LAYOUT  = 2'd2;

    typedef enum logic [MODE_W-1:0] {
        MODE_USAGE_PAL = 3'd0,
        MODE_FREQ_PAL  = 3'd1,
        MODE_SAMPLE    = 3'd2,
        MODE_END_COL   = 3'd3,
        MODE_READ      = 3'd4
    } t_mode;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SAMP_A,
        ST_SAMP_B,
        ST_DIV_LD,
        ST_DIV,
        ST_FREQ_RD,
        ST_FREQ_WR,
        ST_MOD_LD,
        ST_MOD,
        ST_FRM_RD,
        ST_FRM_OUT
    } t_state;

    typedef struct packed {
        logic load;
        logic pal_wr_usage;
        logic pal_wr_freq;
        logic adv;
        logic clr_start;
        logic clr_step;
        logic samp_rd;
        logic usage_wr;
        logic div_ld_freq;
        logic div_ld_mod;
        logic div_step;
        logic freq_rd;
        logic freq_wr;
        logic frm_rd;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic              cfg_hit;
        logic              core_ok;
        logic              layout;
        logic              clr_last;
        logic              out_free;
        logic [MODE_W-1:0] in_mode;
    } t_status;

endpackage
`default_nettype wire

/* hdl/chsr_ctrl.sv */
// Sequencing state machine for the heat-map strip renderer.
`default_nettype none
module chsr_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    input  wire chsr_pkg::t_status i_stat,
    output chsr_pkg::t_cmd        o_cmd,
    output logic                  o_in_stall
);

    chsr_pkg::t_state                r_state, n_state;
    logic [chsr_pkg::CNT_W-1:0]      r_cnt, n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= chsr_pkg::ST_CLEAR;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // hold the input off while busy and while a register write restarts the clear
    assign o_in_stall = (r_state != chsr_pkg::ST_IDLE) || i_stat.cfg_hit;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        case (r_state)
            chsr_pkg::ST_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_stat.clr_last) n_state = chsr_pkg::ST_IDLE;
            end
            chsr_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    if (i_stat.in_mode == chsr_pkg::MODE_USAGE_PAL) begin
                        o_cmd.pal_wr_usage = 1'b1;
                    end else if (i_stat.in_mode == chsr_pkg::MODE_FREQ_PAL) begin
                        o_cmd.pal_wr_freq = 1'b1;
                    end else if (i_stat.in_mode == chsr_pkg::MODE_SAMPLE) begin
                        n_state = chsr_pkg::ST_SAMP_A;
                    end else if (i_stat.in_mode == chsr_pkg::MODE_END_COL) begin
                        o_cmd.adv = 1'b1;
                    end else if (i_stat.in_mode == chsr_pkg::MODE_READ) begin
                        n_state = chsr_pkg::ST_MOD_LD;
                    end
                end
            end
            chsr_pkg::ST_SAMP_A: begin
                // drop samples for cores beyond the active count
                if (i_stat.core_ok) begin
                    o_cmd.samp_rd = 1'b1;
                    n_state       = chsr_pkg::ST_SAMP_B;
                end else begin
                    n_state = chsr_pkg::ST_IDLE;
                end
            end
            chsr_pkg::ST_SAMP_B: begin
                o_cmd.usage_wr = 1'b1;
                n_state = i_stat.layout ? chsr_pkg::ST_DIV_LD : chsr_pkg::ST_IDLE;
            end
            chsr_pkg::ST_DIV_LD: begin
                o_cmd.div_ld_freq = 1'b1;
                n_cnt   = chsr_pkg::DIV_STEPS;
                n_state = chsr_pkg::ST_DIV;
            end
            chsr_pkg::ST_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == chsr_pkg::CNT_W'(1)) n_state = chsr_pkg::ST_FREQ_RD;
            end
            chsr_pkg::ST_FREQ_RD: begin
                o_cmd.freq_rd = 1'b1;
                n_state = chsr_pkg::ST_FREQ_WR;
            end
            chsr_pkg::ST_FREQ_WR: begin
                o_cmd.freq_wr = 1'b1;
                n_state = chsr_pkg::ST_IDLE;
            end
            chsr_pkg::ST_MOD_LD: begin
                o_cmd.div_ld_mod = 1'b1;
                n_cnt   = chsr_pkg::MOD_STEPS;
                n_state = chsr_pkg::ST_MOD;
            end
            chsr_pkg::ST_MOD: begin
                o_cmd.div_step = 1'b1;
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == chsr_pkg::CNT_W'(1)) n_state = chsr_pkg::ST_FRM_RD;
            end
            chsr_pkg::ST_FRM_RD: begin
                o_cmd.frm_rd = 1'b1;
                n_state = chsr_pkg::ST_FRM_OUT;
            end
            chsr_pkg::ST_FRM_OUT: begin
                // hold until the output register is free
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = chsr_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = chsr_pkg::ST_CLEAR;
            end
        endcase

        // any write to a known configuration register restarts the clearing pass
        if (i_stat.cfg_hit) begin
            o_cmd           = '0;
            o_cmd.clr_start = 1'b1;
            n_state         = chsr_pkg::ST_CLEAR;
        end
    end

endmodule
`default_nettype wire

/* hdl/chsr_dpath.sv */
// Datapath: configuration, palettes, frame store, shift-subtract divider and output register.
`default_nettype none
module chsr_dpath (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire chsr_pkg::t_cmd                    i_cmd,
    output chsr_pkg::t_status                      o_stat,
    input  wire logic                              i_cfg_valid,
    input  wire logic [chsr_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [chsr_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  wire logic [chsr_pkg::MODE_W-1:0]       i_mode,
    input  wire logic [chsr_pkg::CORE_W-1:0]       i_core,
    input  wire logic [chsr_pkg::USAGE_W-1:0]      i_usage,
    input  wire logic [chsr_pkg::FREQ_W-1:0]       i_freq_now,
    input  wire logic [chsr_pkg::FREQ_W-1:0]       i_freq_low,
    input  wire logic [chsr_pkg::FREQ_W-1:0]       i_freq_high,
    input  wire logic [chsr_pkg::PAL_AW-1:0]       i_table_index,
    input  wire logic [chsr_pkg::PIX_W-1:0]        i_color,
    input  wire logic [chsr_pkg::ROW_W-1:0]        i_row,
    input  wire logic [chsr_pkg::COL_W-1:0]        i_column,
    input  wire logic                              i_out_stall,
    output logic                                   o_out_valid,
    output logic [chsr_pkg::PIX_W-1:0]             o_pixel_color
);

    // memories
    logic [chsr_pkg::PIX_W-1:0] r_upal [chsr_pkg::PALETTE_SIZE];
    logic [chsr_pkg::PIX_W-1:0] r_fpal [chsr_pkg::PALETTE_SIZE];
    logic [chsr_pkg::PIX_W-1:0] r_frame [chsr_pkg::FRAME_DEPTH];

    // configuration
    logic [chsr_pkg::CFG_COLS_W-1:0] r_cols;
    logic [chsr_pkg::CFG_CORE_W-1:0] r_cores;
    logic                            r_layout;

    // latched item
    logic [chsr_pkg::CORE_W-1:0]  r_core;
    logic [chsr_pkg::USAGE_W-1:0] r_usage;
    logic [chsr_pkg::FREQ_W-1:0]  r_fnow, r_flow, r_fhigh;
    logic [chsr_pkg::ROW_W-1:0]   r_row;
    logic [chsr_pkg::COL_W-1:0]   r_column;

    logic [chsr_pkg::COL_W-1:0]    r_wc;
    logic [chsr_pkg::FRAME_AW-1:0] r_clr_addr;

    logic [chsr_pkg::PIX_W-1:0] r_upal_q, r_fpal_q, r_frm_q;
    logic [chsr_pkg::NUM_W-1:0] r_num;
    logic                       r_fzero, r_fsat, r_row_ok;

    logic [chsr_pkg::FREQ_W-1:0] r_rem, r_dvd, r_dsr;
    logic [chsr_pkg::QUO_W-1:0]  r_quo;

    logic                        r_out_valid;
    logic [chsr_pkg::PIX_W-1:0]  r_pix;

    // effective configuration
    logic [chsr_pkg::CFG_COLS_W-1:0] w_width;
    logic [chsr_pkg::CFG_CORE_W-1:0] w_cores;
    logic [chsr_pkg::CFG_CORE_W:0]   w_rows;
    logic                            w_cfg_hit;

    assign w_width = (r_cols == '0) ? chsr_pkg::CFG_COLS_W'(1) :
                     (r_cols > chsr_pkg::COLS_MAX) ? chsr_pkg::COLS_MAX : r_cols;
    assign w_cores = (r_cores == '0) ? chsr_pkg::CFG_CORE_W'(1) :
                     (r_cores > chsr_pkg::CORES_LIMIT) ? chsr_pkg::CORES_LIMIT : r_cores;
    assign w_rows  = r_layout ? {w_cores, 1'b0} : {1'b0, w_cores};

    assign w_cfg_hit = i_cfg_valid && ((i_cfg_index == chsr_pkg::CFG_COLUMNS) ||
                                       (i_cfg_index == chsr_pkg::CFG_CORES) ||
                                       (i_cfg_index == chsr_pkg::CFG_LAYOUT));

    // item arithmetic
    logic [chsr_pkg::PAL_AW-1:0]   w_uidx, w_fidx;
    logic [chsr_pkg::FREQ_W-1:0]   w_fdiff;
    logic [chsr_pkg::COL_W:0]      w_sum;
    logic [chsr_pkg::COL_W:0]      w_wc_inc;
    logic [chsr_pkg::FREQ_W:0]     w_trial, w_sub;
    logic                          w_ge;
    logic [chsr_pkg::CFG_CORE_W:0] w_frow_sum;
    logic [chsr_pkg::ROW_W-1:0]    w_frow;

    assign w_uidx  = (r_usage > chsr_pkg::CLAMP_MAX) ? chsr_pkg::CLAMP_MAX : r_usage;
    assign w_fidx  = r_fzero ? '0 : (r_fsat ? chsr_pkg::CLAMP_MAX : r_quo);
    assign w_fdiff = r_fnow - r_flow;
    assign w_sum   = {1'b0, r_wc} + {1'b0, r_column};
    assign w_wc_inc = {1'b0, r_wc} + 1'b1;
    assign w_trial = {r_rem, r_dvd[chsr_pkg::FREQ_W-1]};
    assign w_sub   = w_trial - {1'b0, r_dsr};
    assign w_ge    = (w_trial >= {1'b0, r_dsr});
    assign w_frow_sum = {1'b0, w_cores} + (chsr_pkg::CFG_CORE_W+1)'(r_core);
    assign w_frow  = w_frow_sum[chsr_pkg::ROW_W-1:0];

    // configuration and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols      <= chsr_pkg::COLS_RESET;
            r_cores     <= chsr_pkg::CORES_RESET;
            r_layout    <= chsr_pkg::LAYOUT_RESET;
            r_wc        <= '0;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid && (i_cfg_index == chsr_pkg::CFG_COLUMNS))
                r_cols <= i_cfg_data[chsr_pkg::CFG_COLS_W-1:0];
            if (i_cfg_valid && (i_cfg_index == chsr_pkg::CFG_CORES))
                r_cores <= i_cfg_data[chsr_pkg::CFG_CORE_W-1:0];
            if (i_cfg_valid && (i_cfg_index == chsr_pkg::CFG_LAYOUT))
                r_layout <= i_cfg_data[0];

            if (i_cmd.clr_start) begin
                r_wc       <= '0;
                r_clr_addr <= '0;
            end else begin
                if (i_cmd.clr_step) r_clr_addr <= r_clr_addr + 1'b1;
                if (i_cmd.adv) begin
                    // advance with wrap at the active width
                    r_wc <= (w_wc_inc >= w_width) ? '0 : w_wc_inc[chsr_pkg::COL_W-1:0];
                end
            end

            if (i_cmd.out_load) r_out_valid <= 1'b1;
            else if (!i_out_stall) r_out_valid <= 1'b0;
        end
    end

    // item capture, multiply, divider and output payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_core   <= i_core;
            r_usage  <= i_usage;
            r_fnow   <= i_freq_now;
            r_flow   <= i_freq_low;
            r_fhigh  <= i_freq_high;
            r_row    <= i_row;
            r_column <= i_column;
        end
        if (i_cmd.samp_rd) begin
            r_num   <= chsr_pkg::NUM_W'(w_fdiff) * chsr_pkg::NUM_W'(chsr_pkg::FREQ_SCALE);
            r_fzero <= !((r_fhigh > r_flow) && (r_fnow > r_flow));
            // quotient reaches the scale exactly when now >= high
            r_fsat  <= (r_fnow >= r_fhigh);
        end
        if (i_cmd.div_ld_freq) begin
            r_rem <= r_num[chsr_pkg::NUM_W-1:chsr_pkg::QUO_W];
            r_dvd <= {r_num[chsr_pkg::QUO_W-1:0], (chsr_pkg::FREQ_W-chsr_pkg::QUO_W)'(0)};
            r_dsr <= r_fhigh - r_flow;
            r_quo <= '0;
        end else if (i_cmd.div_ld_mod) begin
            r_rem    <= '0;
            r_dvd    <= {w_sum, (chsr_pkg::FREQ_W-chsr_pkg::COL_W-1)'(0)};
            r_dsr    <= chsr_pkg::FREQ_W'(w_width);
            r_quo    <= '0;
            r_row_ok <= ({1'b0, r_row} < w_rows);
        end else if (i_cmd.div_step) begin
            r_rem <= w_ge ? w_sub[chsr_pkg::FREQ_W-1:0] : w_trial[chsr_pkg::FREQ_W-1:0];
            r_dvd <= {r_dvd[chsr_pkg::FREQ_W-2:0], 1'b0};
            r_quo <= {r_quo[chsr_pkg::QUO_W-2:0], w_ge};
        end
        if (i_cmd.out_load) r_pix <= r_row_ok ? r_frm_q : '0;
    end

    // palettes
    always_ff @(posedge i_clk) begin
        if (i_cmd.pal_wr_usage && (i_table_index < chsr_pkg::PAL_AW'(chsr_pkg::PALETTE_SIZE)))
            r_upal[i_table_index] <= i_color;
        if (i_cmd.samp_rd) r_upal_q <= r_upal[w_uidx];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.pal_wr_freq && (i_table_index < chsr_pkg::PAL_AW'(chsr_pkg::PALETTE_SIZE)))
            r_fpal[i_table_index] <= i_color;
        if (i_cmd.freq_rd) r_fpal_q <= r_fpal[w_fidx];
    end

    // frame store: one write port, one read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_step)
            r_frame[r_clr_addr] <= '0;
        else if (i_cmd.usage_wr)
            r_frame[{1'b0, r_core, r_wc}] <= r_upal_q;
        else if (i_cmd.freq_wr)
            r_frame[{w_frow, r_wc}] <= r_fpal_q;
        if (i_cmd.frm_rd) r_frm_q <= r_frame[{r_row, r_rem[chsr_pkg::COL_W-1:0]}];
    end

    assign o_stat.cfg_hit  = w_cfg_hit;
    assign o_stat.core_ok  = ({1'b0, r_core} < w_cores);
    assign o_stat.layout   = r_layout;
    assign o_stat.clr_last = (r_clr_addr == chsr_pkg::FRAME_AW'(chsr_pkg::FRAME_DEPTH - 1));
    assign o_stat.out_free = !r_out_valid || !i_out_stall;
    assign o_stat.in_mode  = i_mode;

    assign o_out_valid   = r_out_valid;
    assign o_pixel_color = r_pix;

endmodule
`default_nettype wire

/* hdl/cpu_heatmap_strip_renderer_unit.sv */
// Top level of the scrolling per-core heat-map strip renderer.
// Palette writes and end-of-column items are done on acceptance; a sample in layout 1
// also runs the frequency divide (10 steps of the shift-subtract divider); a read runs
// 9 divider steps for the column modulo plus the frame read before its result.
// Reset (synchronous, active low) and every write to a known configuration register start
// a clearing pass over the frame store, one entry a cycle, during which no item is accepted.
`default_nettype none
module cpu_heatmap_strip_renderer_unit (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // input items
    input  wire logic                              i_in_valid,
    output logic                                   o_in_stall,
    input  wire logic [chsr_pkg::MODE_W-1:0]       i_mode,
    input  wire logic [chsr_pkg::CORE_W-1:0]       i_core,
    input  wire logic [chsr_pkg::USAGE_W-1:0]      i_usage,
    input  wire logic [chsr_pkg::FREQ_W-1:0]       i_freq_now,
    input  wire logic [chsr_pkg::FREQ_W-1:0]       i_freq_low,
    input  wire logic [chsr_pkg::FREQ_W-1:0]       i_freq_high,
    input  wire logic [chsr_pkg::PAL_AW-1:0]       i_table_index,
    input  wire logic [chsr_pkg::PIX_W-1:0]        i_color,
    input  wire logic [chsr_pkg::ROW_W-1:0]        i_row,
    input  wire logic [chsr_pkg::COL_W-1:0]        i_column,
    // result items
    output logic                                   o_out_valid,
    input  wire logic                              i_out_stall,
    output logic [chsr_pkg::PIX_W-1:0]             o_pixel_color,
    // configuration writes
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [chsr_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [chsr_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    chsr_pkg::t_cmd    w_cmd;
    chsr_pkg::t_status w_stat;

    // Register writes are always taken; a write to a known register
    // restarts the frame clear and rewinds the column pointer.
    assign o_cfg_ready = 1'b1;

    // Controller: walks each item through its steps (capture, palette
    // lookup, divide or modulo, frame write or read, result handoff).
    chsr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd),
        .o_in_stall (o_in_stall)
    );

    // Datapath: holds the palettes, the circular frame store, the shared
    // shift-subtract divider and the output register that lets a result
    // wait while the next item is taken.
    chsr_dpath u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_mode        (i_mode),
        .i_core        (i_core),
        .i_usage       (i_usage),
        .i_freq_now    (i_freq_now),
        .i_freq_low    (i_freq_low),
        .i_freq_high   (i_freq_high),
        .i_table_index (i_table_index),
        .i_color       (i_color),
        .i_row         (i_row),
        .i_column      (i_column),
        .i_out_stall   (i_out_stall),
        .o_out_valid   (o_out_valid),
        .o_pixel_color (o_pixel_color)
    );

    // a result appears only after the read path loaded it
    a_out_from_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(w_cmd.out_load))
        else $error("result valid without a read load");

    // no item enters while the frame store is being cleared
    a_stall_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.clr_step |-> o_in_stall)
        else $error("item accepted during frame clear");

    // the single frame write port is never claimed twice
    a_one_writer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({w_cmd.clr_step, w_cmd.usage_wr, w_cmd.freq_wr}))
        else $error("frame store write conflict");

    // a register write sends the block into the clearing pass
    a_cfg_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stat.cfg_hit |=> (o_in_stall && (w_cmd.clr_step || w_cmd.clr_start)))
        else $error("configuration write did not start a clear");

endmodule
`default_nettype wire

/* tb/cpu_heatmap_strip_renderer_unit_tb.sv */
// Self-checking testbench for the heat-map strip renderer: predicted pixel reads vs. the block.
`timescale 1ns / 100ps
module cpu_heatmap_strip_renderer_unit_tb;
    import chsr_pkg::*;

    localparam int CLK_HALF_NS = 6;
    // Watchdog limit on the whole run, well past what a correct run needs.
    localparam longint TIMEOUT_NS = 24_000_000;
    // A sample in layout 1 keeps the block busy with no result to show for it.
    localparam int SETTLE_CYCLES = 24;
    localparam int END_CYCLES = 40;
    localparam int DRAIN_LIMIT = 20000;
    localparam int HOLDOFF_CYCLES = 400;
    // Configuration index past the end of the register list; the block must ignore it.
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    // Mode codes past the last operation; they do nothing.
    localparam int UNUSED_MODE_LO = 5;
    localparam int UNUSED_MODE_HI = 7;

    // One input item as the block sees it, field for field.
    typedef struct {
        logic [MODE_W-1:0]  mode;
        logic [CORE_W-1:0]  core;
        logic [USAGE_W-1:0] usage;
        logic [FREQ_W-1:0]  freq_now;
        logic [FREQ_W-1:0]  freq_low;
        logic [FREQ_W-1:0]  freq_high;
        logic [PAL_AW-1:0]  table_index;
        logic [PIX_W-1:0]   color;
        logic [ROW_W-1:0]   row;
        logic [COL_W-1:0]   column;
    } t_strip_item;

    // Clock, reset and every block input start at a known value.
    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [MODE_W-1:0]  in_mode = '0;
    logic [CORE_W-1:0]  in_core = '0;
    logic [USAGE_W-1:0] in_usage = '0;
    logic [FREQ_W-1:0]  in_freq_now = '0;
    logic [FREQ_W-1:0]  in_freq_low = '0;
    logic [FREQ_W-1:0]  in_freq_high = '0;
    logic [PAL_AW-1:0]  in_table_index = '0;
    logic [PIX_W-1:0]   in_color = '0;
    logic [ROW_W-1:0]   in_row = '0;
    logic [COL_W-1:0]   in_column = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [PIX_W-1:0] out_pixel;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // Shadow copy of the renderer state, advanced at every accepted item.
    logic [PIX_W-1:0] usage_pal_model [PALETTE_SIZE];
    logic [PIX_W-1:0] freq_pal_model [PALETTE_SIZE];
    bit               usage_pal_set [PALETTE_SIZE];
    bit               freq_pal_set [PALETTE_SIZE];
    logic [PIX_W-1:0] frame_model [FRAME_DEPTH];
    int unsigned      wcol_model;
    logic [CFG_COLS_W-1:0] cols_model;
    logic [CFG_CORE_W-1:0] cores_model;
    logic                  layout_model;

    logic [PIX_W-1:0] expected_pixels [$];
    logic [PIX_W-1:0] want_pixel;
    int mismatch_count = 0;
    int items_sent = 0;
    int burst_left = 0;
    int holdoff_len = 0;

    cpu_heatmap_strip_renderer_unit dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .o_in_stall    (in_stall),
        .i_mode        (in_mode),
        .i_core        (in_core),
        .i_usage       (in_usage),
        .i_freq_now    (in_freq_now),
        .i_freq_low    (in_freq_low),
        .i_freq_high   (in_freq_high),
        .i_table_index (in_table_index),
        .i_color       (in_color),
        .i_row         (in_row),
        .i_column      (in_column),
        .o_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .o_pixel_color (out_pixel),
        .i_cfg_valid   (cfg_valid),
        .o_cfg_ready   (cfg_ready),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data)
    );

    always #(CLK_HALF_NS) clk = ~clk;

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // Out-of-range register values fold onto the nearest legal one.
    function automatic int unsigned eff_columns();
        if (cols_model == 0) return 1;
        if (cols_model > COLS_MAX) return WIDTH_MAX;
        return cols_model;
    endfunction

    function automatic int unsigned eff_cores();
        if (cores_model == 0) return 1;
        if (cores_model > CORES_LIMIT) return CORES_MAX;
        return cores_model;
    endfunction

    function automatic int unsigned active_rows();
        return layout_model ? 2 * eff_cores() : eff_cores();
    endfunction

    // Usage is per mille; anything past the top entry clamps onto it.
    function automatic logic [PAL_AW-1:0] usage_entry(logic [USAGE_W-1:0] usage);
        return (usage > CLAMP_MAX) ? CLAMP_MAX : usage;
    endfunction

    // Frequency scaled into 0..999 of the low..high span; an empty span or a
    // value at or below the low end gives entry 0.
    function automatic logic [PAL_AW-1:0] freq_entry(logic [FREQ_W-1:0] now,
                                                     logic [FREQ_W-1:0] low,
                                                     logic [FREQ_W-1:0] high);
        longint unsigned q;
        q = 0;
        if (high > low && now > low)
            q = ((64'(now) - 64'(low)) * 64'(FREQ_SCALE)) / (64'(high) - 64'(low));
        if (q > 64'(CLAMP_MAX)) q = 64'(CLAMP_MAX);
        return PAL_AW'(q);
    endfunction

    function automatic void clear_frame_model();
        foreach (frame_model[i]) frame_model[i] = '0;
        wcol_model = 0;
    endfunction

    // Any known register clears the strip, even when its value is unchanged;
    // the palettes survive.
    function automatic void apply_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_COLUMNS: cols_model = data;
            CFG_CORES:   cores_model = data[CFG_CORE_W-1:0];
            CFG_LAYOUT:  layout_model = data[0];
            default:     return;
        endcase
        clear_frame_model();
    endfunction

    // Advance the shadow state by one accepted item; queue the pixel a read returns.
    function automatic void track_strip_item(t_strip_item it);
        int unsigned width;
        int unsigned cores;
        int unsigned phys;
        logic [PIX_W-1:0] pix;
        width = eff_columns();
        cores = eff_cores();
        if (wcol_model >= width) wcol_model = 0;
        case (it.mode)
            MODE_USAGE_PAL: begin
                if (it.table_index < PALETTE_SIZE) begin
                    usage_pal_model[it.table_index] = it.color;
                    usage_pal_set[it.table_index] = 1'b1;
                end
            end
            MODE_FREQ_PAL: begin
                if (it.table_index < PALETTE_SIZE) begin
                    freq_pal_model[it.table_index] = it.color;
                    freq_pal_set[it.table_index] = 1'b1;
                end
            end
            MODE_SAMPLE: begin
                if (it.core < cores) begin
                    frame_model[it.core * WIDTH_MAX + wcol_model] =
                        usage_pal_model[usage_entry(it.usage)];
                    if (layout_model)
                        frame_model[(cores + it.core) * WIDTH_MAX + wcol_model] =
                            freq_pal_model[freq_entry(it.freq_now, it.freq_low, it.freq_high)];
                end
            end
            MODE_END_COL: begin
                wcol_model++;
                if (wcol_model >= width) wcol_model = 0;
            end
            MODE_READ: begin
                pix = '0;
                if (it.row < active_rows()) begin
                    // Logical column 0 is the oldest, i.e. the one the pointer sits on.
                    phys = (wcol_model + it.column) % width;
                    pix = frame_model[it.row * WIDTH_MAX + phys];
                end
                expected_pixels.push_back(pix);
            end
            default: ;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    task automatic report_failure(input string msg);
        mismatch_count++;
        $display("[%0t] MISMATCH %s", $realtime, msg);
    endtask

    // Compare every accepted result against the oldest waiting prediction.
    always @(posedge clk) begin
        if (rst_n && out_valid === 1'b1 && out_stall == 1'b0) begin
            if (expected_pixels.size() == 0) begin
                report_failure($sformatf("unexpected result pixel_color=%h", out_pixel));
            end else begin
                want_pixel = expected_pixels.pop_front();
                if (out_pixel !== want_pixel)
                    report_failure($sformatf("pixel_color got %h want %h", out_pixel, want_pixel));
            end
        end
    end

    // ------------------------------------------------------------------
    // Result side: random stall patterns that change from segment to segment, plus a
    // long hold-off on request.
    // ------------------------------------------------------------------
    initial begin : result_receiver
        int seg_left;
        int style;
        int period;
        int tick;
        int hold_left;
        seg_left = 0;
        style = 0;
        period = 2;
        tick = 0;
        hold_left = 0;
        forever begin
            @(posedge clk);
            if (holdoff_len > 0) begin
                hold_left = holdoff_len;
                holdoff_len = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end else begin
                if (seg_left == 0) begin
                    seg_left = $urandom_range(20, 200);
                    style = $urandom_range(0, 3);
                    period = $urandom_range(2, 7);
                end
                seg_left--;
                tick++;
                case (style)
                    0:       out_stall <= 1'b0;
                    1:       out_stall <= ($urandom_range(0, 3) == 0);
                    2:       out_stall <= ($urandom_range(0, 9) < 7);
                    default: out_stall <= ((tick % period) == 0);
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Every field random; callers override what the operation needs.
    function automatic t_strip_item item_of(logic [MODE_W-1:0] mode);
        t_strip_item it;
        it.mode = mode;
        it.core = CORE_W'($urandom);
        it.usage = USAGE_W'($urandom);
        it.freq_now = FREQ_W'($urandom);
        it.freq_low = FREQ_W'($urandom);
        it.freq_high = FREQ_W'($urandom);
        it.table_index = PAL_AW'($urandom);
        it.color = $urandom;
        it.row = ROW_W'($urandom);
        it.column = COL_W'($urandom);
        return it;
    endfunction

    // Sample with usage biased to the clamp edges and frequencies spread over
    // in-span, below-low, empty-span, above-high and full-scale cases.
    function automatic t_strip_item random_sample(logic [CORE_W-1:0] core);
        t_strip_item it;
        int unsigned lo;
        int unsigned hi;
        it = item_of(MODE_SAMPLE);
        it.core = core;
        if ($urandom_range(0, 3) == 0) begin
            case ($urandom_range(0, 3))
                0:       it.usage = '0;
                1:       it.usage = CLAMP_MAX;
                2:       it.usage = CLAMP_MAX + 1'b1;
                default: it.usage = '1;
            endcase
        end
        case ($urandom_range(0, 5))
            1: begin
                lo = $urandom_range(0, 60000);
                hi = $urandom_range(lo + 1, 65535);
                it.freq_low = FREQ_W'(lo);
                it.freq_high = FREQ_W'(hi);
                it.freq_now = FREQ_W'($urandom_range(lo, hi));
            end
            2: begin
                lo = $urandom_range(1, 65535);
                it.freq_low = FREQ_W'(lo);
                it.freq_now = FREQ_W'($urandom_range(0, lo - 1));
            end
            3: begin
                hi = $urandom_range(0, 65535);
                it.freq_high = FREQ_W'(hi);
                it.freq_low = FREQ_W'($urandom_range(hi, 65535));
            end
            4: begin
                lo = $urandom_range(0, 30000);
                hi = $urandom_range(lo + 1, 40000);
                it.freq_low = FREQ_W'(lo);
                it.freq_high = FREQ_W'(hi);
                it.freq_now = FREQ_W'($urandom_range(hi, 65535));
            end
            5: begin
                it.freq_low = '0;
                it.freq_high = '1;
                it.freq_now = $urandom_range(0, 1) ? '1 : '0;
            end
            default: ;
        endcase
        return it;
    endfunction

    // Offer one item and hold it until accepted. Bursts of random length with
    // random gaps between them; some bursts run long with no gap at all.
    task automatic send_item(input t_strip_item it);
        int gap;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 20) : $urandom_range(0, 2);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_mode <= it.mode;
        in_core <= it.core;
        in_usage <= it.usage;
        in_freq_now <= it.freq_now;
        in_freq_low <= it.freq_low;
        in_freq_high <= it.freq_high;
        in_table_index <= it.table_index;
        in_color <= it.color;
        in_row <= it.row;
        in_column <= it.column;
        in_valid <= 1'b1;
        do @(posedge clk); while (in_stall !== 1'b0);
        track_strip_item(it);
        items_sent++;
    endtask

    // Load any palette entry the sample will look up before sending it, so
    // that no never-written entry is ever read.
    task automatic send_sample(input t_strip_item it);
        t_strip_item fill;
        if (it.core < eff_cores()) begin
            fill = item_of(MODE_USAGE_PAL);
            fill.table_index = usage_entry(it.usage);
            if (!usage_pal_set[fill.table_index]) send_item(fill);
            fill = item_of(MODE_FREQ_PAL);
            fill.table_index = freq_entry(it.freq_now, it.freq_low, it.freq_high);
            if (layout_model && !freq_pal_set[fill.table_index]) send_item(fill);
        end
        send_item(it);
    endtask

    task automatic send_read(input int row, input int column);
        t_strip_item it;
        it = item_of(MODE_READ);
        it.row = ROW_W'(row);
        it.column = COL_W'(column);
        send_item(it);
    endtask

    task automatic send_mode(input logic [MODE_W-1:0] mode);
        send_item(item_of(mode));
    endtask

    // Drop valid and hold until every predicted result has come back.
    task automatic wait_drain();
        int waited;
        in_valid <= 1'b0;
        @(posedge clk);
        waited = 0;
        while (expected_pixels.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge clk);
            waited++;
        end
        if (expected_pixels.size() != 0)
            report_failure($sformatf("%0d results never arrived", expected_pixels.size()));
    endtask

    // Drain, then let a sample still in flight finish before touching registers.
    task automatic settle();
        wait_drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_index <= idx;
        cfg_data <= data;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (cfg_ready !== 1'b1);
        apply_cfg(idx, data);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Write all three registers; unused upper data bits carry random noise.
    task automatic set_strip_config(input logic [CFG_COLS_W-1:0] cols,
                                    input logic [CFG_CORE_W-1:0] cores,
                                    input logic lay);
        settle();
        cfg_write(CFG_COLUMNS, cols);
        cfg_write(CFG_CORES, {5'($urandom), cores});
        cfg_write(CFG_LAYOUT, {8'($urandom), lay});
    endtask

    // Mostly well-formed column sweeps and reads, with palette writes, stray
    // samples, unused modes and fully random items mixed in.
    task automatic run_random_phase(input int n);
        int stop_at;
        int pick;
        int c;
        t_strip_item it;
        stop_at = items_sent + n;
        while (items_sent < stop_at) begin
            it = item_of(MODE_W'($urandom));
            pick = $urandom_range(0, 99);
            if (pick < 35) begin
                for (c = 0; c < eff_cores(); c++) begin
                    if ($urandom_range(0, 7) != 0) send_sample(random_sample(CORE_W'(c)));
                end
                send_mode(MODE_END_COL);
            end else if (pick < 65) begin
                it.mode = MODE_READ;
                if ($urandom_range(0, 4) != 0)
                    it.row = ROW_W'($urandom_range(0, active_rows() - 1));
                send_item(it);
            end else if (pick < 75) begin
                send_sample(random_sample(CORE_W'($urandom)));
            end else if (pick < 83) begin
                send_mode(MODE_END_COL);
            end else if (pick < 91) begin
                it.mode = $urandom_range(0, 1) ? MODE_FREQ_PAL : MODE_USAGE_PAL;
                send_item(it);
            end else if (pick < 95) begin
                send_mode(MODE_W'($urandom_range(UNUSED_MODE_LO, UNUSED_MODE_HI)));
            end else if (it.mode == MODE_SAMPLE) begin
                send_sample(it);
            end else begin
                send_item(it);
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset leaves the strip all zero: present and absent rows alike read 0.
    task automatic test_reset_clear();
        send_read(0, 0);
        send_read(1, 128);
        send_read(2, 0);
        send_read(15, 255);
    endtask

    // Palette extremes, ignored palette indexes, every frequency corner, an
    // absent core, unused modes and reads across the wrap.
    task automatic test_palette_clamps();
        t_strip_item it;
        it = item_of(MODE_USAGE_PAL);
        it.table_index = '0;
        send_item(it);
        it = item_of(MODE_USAGE_PAL);
        it.table_index = CLAMP_MAX;
        send_item(it);
        it = item_of(MODE_FREQ_PAL);
        it.table_index = '0;
        send_item(it);
        it = item_of(MODE_FREQ_PAL);
        it.table_index = CLAMP_MAX;
        send_item(it);
        // Index past the palette: drop the write.
        it = item_of(MODE_USAGE_PAL);
        it.table_index = CLAMP_MAX + 1'b1;
        send_item(it);
        it = item_of(MODE_FREQ_PAL);
        it.table_index = '1;
        send_item(it);

        // Zero usage, frequency sitting on the low end.
        it = random_sample('0);
        it.usage = '0;
        it.freq_now = 16'd100;
        it.freq_low = 16'd100;
        it.freq_high = 16'd200;
        send_sample(it);
        send_read(0, 0);
        send_read(1, 0);
        send_mode(MODE_END_COL);

        // Full-scale usage and frequency: both clamp to the top entry.
        it.usage = '1;
        it.freq_now = '1;
        it.freq_low = '0;
        it.freq_high = '1;
        send_sample(it);
        send_mode(MODE_END_COL);

        // Frequency below the low end.
        it.usage = CLAMP_MAX + 1'b1;
        it.freq_now = 16'd10;
        it.freq_low = 16'd500;
        it.freq_high = 16'd1000;
        send_sample(it);
        send_mode(MODE_END_COL);

        // Empty span: high not above low.
        it.usage = CLAMP_MAX;
        it.freq_now = 16'd60000;
        it.freq_low = 16'd100;
        it.freq_high = 16'd100;
        send_sample(it);
        send_mode(MODE_END_COL);

        // Frequency above the high end.
        it.usage = '0;
        it.freq_now = 16'd3000;
        it.freq_low = 16'd1000;
        it.freq_high = 16'd2000;
        send_sample(it);

        // Core past the core count: drop the sample.
        it = random_sample(CORE_W'(CORES_MAX - 1));
        send_sample(it);
        send_mode(MODE_W'(UNUSED_MODE_LO));
        send_mode(MODE_W'(UNUSED_MODE_LO + 1));
        send_mode(MODE_W'(UNUSED_MODE_HI));

        // Logical columns near the top wrap around onto early physical columns.
        send_read(0, 255);
        send_read(1, 252);
        send_read(1, 253);
        send_read(2, 7);
        send_read(15, 0);
    endtask

    // A write to an index past the register list must not clear the strip.
    task automatic test_ignored_cfg_index();
        settle();
        cfg_write(CFG_UNUSED, CFG_DATA_W'($urandom));
        send_read(0, 255);
        send_read(1, 255);
        send_read(1, 252);
    endtask

    // Zero columns and cores fold to 1; oversize values fold to the maximum.
    task automatic test_cfg_clamps();
        set_strip_config('0, '0, 1'b0);
        send_sample(random_sample('0));
        send_read(0, 0);
        send_read(0, 200);
        send_read(1, 0);
        send_mode(MODE_END_COL);
        send_read(0, 0);

        set_strip_config('1, '1, 1'b1);
        send_sample(random_sample(CORE_W'(CORES_MAX - 1)));
        send_read(CORES_MAX - 1, 0);
        send_read(15, 0);
        send_read(15, 255);
    endtask

    // Random traffic over a spread of settings, extremes among them.
    task automatic test_random_traffic();
        set_strip_config(COLS_RESET, CORES_RESET, LAYOUT_RESET);
        run_random_phase(160);
        set_strip_config(9'd1, 4'd8, 1'b1);
        run_random_phase(160);
        set_strip_config(9'd256, 4'd8, 1'b1);
        run_random_phase(200);
        set_strip_config(9'd2, 4'd8, 1'b0);
        run_random_phase(150);
        set_strip_config(9'd255, 4'd2, 1'b1);
        run_random_phase(150);
        set_strip_config(9'd7, 4'd3, 1'b0);
        run_random_phase(150);
        set_strip_config(9'($urandom_range(1, 256)), 4'($urandom_range(1, 8)), 1'($urandom));
        run_random_phase(150);
        set_strip_config(9'd300, 4'd5, 1'b1);
        run_random_phase(100);
    endtask

    // Hold the result side off for a long stretch while items keep coming, so
    // the block fills up and stalls its input.
    task automatic test_output_holdoff();
        holdoff_len = HOLDOFF_CYCLES;
        repeat (30) send_read($urandom_range(0, active_rows() - 1), $urandom_range(0, 255));
        run_random_phase(20);
        wait_drain();
    endtask

    // Pause the sender until every result is back, then pick up again.
    task automatic test_sender_pause();
        run_random_phase(25);
        wait_drain();
        run_random_phase(25);
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        cols_model = COLS_RESET;
        cores_model = CORES_RESET;
        layout_model = LAYOUT_RESET;
        clear_frame_model();

        // Hold reset once, at the start; the block then clears its frame store.
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_clear();
        test_palette_clamps();
        test_ignored_cfg_index();
        test_cfg_clamps();
        test_random_traffic();
        test_output_holdoff();
        test_sender_pause();

        // Let the last results drain, then give the block time to show strays.
        wait_drain();
        repeat (END_CYCLES) @(posedge clk);
        if (mismatch_count == 0) begin
            $display("cpu_heatmap_strip_renderer_unit_tb: PASS");
        end else begin
            $display("cpu_heatmap_strip_renderer_unit_tb: FAIL");
        end
        $finish;
    end

    // Watchdog: end a hung run.
    initial begin
        #(TIMEOUT_NS);
        $display("cpu_heatmap_strip_renderer_unit_tb: FAIL");
        $finish;
    end

endmodule
